// File: src/memo_hash_table_quadratic_probe_assert.svh
// assertion macros for the memo hash table block
`ifndef MEMO_HASH_TABLE_QUADRATIC_PROBE_ASSERT_SVH
`define MEMO_HASH_TABLE_QUADRATIC_PROBE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define MHTQ_ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("memo hash table assertion failed");
// next-cycle implication
`define MHTQ_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("memo hash table assertion failed");
`else
`define MHTQ_ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons)
`define MHTQ_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif

`endif

// File: src/memo_htqp_pkg.sv
// shared constants, word types and control structs of the memo hash table
package memo_htqp_pkg;

    // table geometry (capacity is a power of two)
    localparam int CAPACITY    = 1024;
    localparam int MAX_PROBES  = 32;
    localparam int VALUE_BITS  = 32;

    localparam int SLOT_BITS   = $clog2(CAPACITY);
    localparam int PROBE_BITS  = $clog2(MAX_PROBES + 1);
    localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
    localparam int CFG_BITS    = 11;
    localparam int CMP_BITS    = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

    // field widths
    localparam int IDX_BITS    = 10;
    localparam int POS_BITS    = 24;
    localparam int KEY_BITS    = IDX_BITS + POS_BITS;
    localparam int FIELD_BITS  = 32;
    localparam int STORE_BITS  = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam int STATUS_BITS = 3;

    // stored word: valid, key, value
    localparam int WORD_BITS   = 1 + KEY_BITS + STORE_BITS;

    // probe step arithmetic
    localparam int SQ_BITS     = 2 * PROBE_BITS;
    localparam int STEP_BITS   = ((SLOT_BITS > SQ_BITS) ? SLOT_BITS : SQ_BITS) + 1;

    // home slot hash
    localparam int SUM_BITS    = POS_BITS + 1;
    localparam int HASH_BITS   = 32;
    localparam int HASH_BASE   = 17;
    localparam int HASH_MULT   = 37;

    localparam logic [CFG_BITS-1:0] MAX_ENTRIES_RESET = CFG_BITS'(768);

    // operation codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // result codes
    localparam logic [STATUS_BITS-1:0] STATUS_HIT      = 3'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_MISS     = 3'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_INSERTED = 3'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_UPDATED  = 3'd3;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 3'd4;

    typedef struct packed {
        logic                  cmd;
        logic [IDX_BITS-1:0]   rule_index;
        logic [POS_BITS-1:0]   position;
        logic [FIELD_BITS-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [FIELD_BITS-1:0]  value_out;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic issue;
        logic check;
        logic respond;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic probe_done;
        logic out_free;
    } ctrl_status_t;

endpackage

// File: src/memo_htqp_ram.sv
// generic single-write, single-read ram with registered read data
module memo_htqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/memo_htqp_ctrl.sv
// controller state machine: clearing sweep, accept, probe loop, response
module memo_htqp_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  memo_htqp_pkg::ctrl_status_t stat,
    output memo_htqp_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_CHECK,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        req_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                cmd.issue  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.probe_done ? S_RESP : S_ISSUE;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/memo_htqp_dp.sv
// datapath: hash, probe address, slot ram, compare, entry count, result word
module memo_htqp_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  memo_htqp_pkg::req_t                  req,
    input  logic                                 rsp_ready,
    output logic                                 rsp_valid,
    output memo_htqp_pkg::rsp_t                  rsp,
    input  logic                                 cfg_we,
    input  logic [memo_htqp_pkg::CFG_BITS-1:0]   cfg_data,
    input  memo_htqp_pkg::ctrl_cmd_t             cmd,
    output memo_htqp_pkg::ctrl_status_t          stat
);

    localparam int SLOT_BITS  = memo_htqp_pkg::SLOT_BITS;
    localparam int PROBE_BITS = memo_htqp_pkg::PROBE_BITS;
    localparam int COUNT_BITS = memo_htqp_pkg::COUNT_BITS;
    localparam int CMP_BITS   = memo_htqp_pkg::CMP_BITS;
    localparam int KEY_BITS   = memo_htqp_pkg::KEY_BITS;
    localparam int STORE_BITS = memo_htqp_pkg::STORE_BITS;
    localparam int WORD_BITS  = memo_htqp_pkg::WORD_BITS;
    localparam int SQ_BITS    = memo_htqp_pkg::SQ_BITS;
    localparam int STEP_BITS  = memo_htqp_pkg::STEP_BITS;
    localparam int SUM_BITS   = memo_htqp_pkg::SUM_BITS;
    localparam int HASH_BITS  = memo_htqp_pkg::HASH_BITS;

    // control registers
    logic [SLOT_BITS-1:0]                   slot_reg;
    logic [SLOT_BITS-1:0]                   slot_next;
    logic [PROBE_BITS-1:0]                  k_reg;
    logic [PROBE_BITS-1:0]                  k_next;
    logic [COUNT_BITS-1:0]                  count_reg;
    logic [COUNT_BITS-1:0]                  count_next;
    logic [memo_htqp_pkg::CFG_BITS-1:0]     max_entries_reg;
    logic                                   rsp_valid_reg;

    // payload registers
    logic                                   cmd_reg;
    logic [KEY_BITS-1:0]                    key_reg;
    logic [STORE_BITS-1:0]                  val_reg;
    logic [memo_htqp_pkg::STATUS_BITS-1:0]  res_status_reg;
    logic [STORE_BITS-1:0]                  res_value_reg;
    memo_htqp_pkg::rsp_t                    rsp_reg;

    // combinational
    logic [SUM_BITS-1:0]                    key_sum;
    logic [HASH_BITS-1:0]                   hash;
    logic [SLOT_BITS-1:0]                   home;
    logic [WORD_BITS-1:0]                   rdata;
    logic [WORD_BITS-1:0]                   wdata;
    logic                                   ram_we;
    logic                                   rd_valid;
    logic [KEY_BITS-1:0]                    rd_key;
    logic [STORE_BITS-1:0]                  rd_value;
    logic                                   hit;
    logic                                   resolved;
    logic                                   exhausted;
    logic                                   room;
    logic                                   do_update;
    logic                                   do_insert;
    logic [memo_htqp_pkg::STATUS_BITS-1:0]  chk_status;
    logic [STORE_BITS-1:0]                  chk_value;
    logic [PROBE_BITS-1:0]                  k_inc;
    logic [SQ_BITS-1:0]                     sq;
    logic [STEP_BITS-1:0]                   step_sum;

    // home slot: (17 + 37 * (index + position)) mod capacity
    assign key_sum = SUM_BITS'(req.rule_index) + SUM_BITS'(req.position);
    assign hash    = HASH_BITS'(memo_htqp_pkg::HASH_BASE)
                   + HASH_BITS'(memo_htqp_pkg::HASH_MULT) * HASH_BITS'(key_sum);
    assign home    = hash[SLOT_BITS-1:0];

    // next probe slot: previous slot plus (k+1) squared
    assign k_inc    = k_reg + PROBE_BITS'(1);
    assign sq       = SQ_BITS'(k_inc) * SQ_BITS'(k_inc);
    assign step_sum = STEP_BITS'(slot_reg) + STEP_BITS'(sq);

    // fields of the word read back
    assign rd_valid = rdata[WORD_BITS-1];
    assign rd_key   = rdata[WORD_BITS-2 -: KEY_BITS];
    assign rd_value = rdata[STORE_BITS-1:0];

    // probe outcome
    assign hit       = rd_valid && (rd_key == key_reg);
    assign resolved  = hit || !rd_valid;
    assign exhausted = !resolved && (k_reg == PROBE_BITS'(memo_htqp_pkg::MAX_PROBES - 1));
    assign room      = CMP_BITS'(count_reg) < CMP_BITS'(max_entries_reg);

    // result and write decision
    always_comb
    begin
        chk_status = memo_htqp_pkg::STATUS_MISS;
        chk_value  = '0;
        do_update  = 1'b0;
        do_insert  = 1'b0;
        if (cmd_reg == memo_htqp_pkg::CMD_GET)
        begin
            if (hit)
            begin
                chk_status = memo_htqp_pkg::STATUS_HIT;
                chk_value  = rd_value;
            end
        end
        else
        begin
            priority if (exhausted)
            begin
                chk_status = memo_htqp_pkg::STATUS_FULL;
            end
            else if (hit)
            begin
                chk_status = memo_htqp_pkg::STATUS_UPDATED;
                do_update  = 1'b1;
            end
            else if (room)
            begin
                chk_status = memo_htqp_pkg::STATUS_INSERTED;
                do_insert  = 1'b1;
            end
            else
            begin
                chk_status = memo_htqp_pkg::STATUS_FULL;
            end
        end
    end

    // ram write: zero words while clearing, full entry on update or insert
    assign ram_we = cmd.clear || (cmd.check && resolved && (do_update || do_insert));
    assign wdata  = cmd.clear ? '0 : {1'b1, key_reg, val_reg};

    memo_htqp_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (memo_htqp_pkg::CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (wdata),
        .re    (cmd.issue),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    // next values of slot pointer, probe count and entry count
    always_comb
    begin
        slot_next  = slot_reg;
        k_next     = k_reg;
        count_next = count_reg;
        if (cmd.clear)
        begin
            slot_next = slot_reg + SLOT_BITS'(1);
        end
        if (cmd.load)
        begin
            slot_next = home;
            k_next    = '0;
        end
        if (cmd.check && !resolved && !exhausted)
        begin
            slot_next = step_sum[SLOT_BITS-1:0];
            k_next    = k_inc;
        end
        if (cmd.check && do_insert && resolved)
        begin
            count_next = count_reg + COUNT_BITS'(1);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg        <= '0;
            k_reg           <= '0;
            count_reg       <= '0;
            max_entries_reg <= memo_htqp_pkg::MAX_ENTRIES_RESET;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            k_reg     <= k_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                max_entries_reg <= cfg_data;
            end
            if (cmd.respond)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= req.cmd;
            key_reg <= {req.rule_index, req.position};
            val_reg <= req.value_in[STORE_BITS-1:0];
        end
        if (cmd.check)
        begin
            res_status_reg <= chk_status;
            res_value_reg  <= chk_value;
        end
        if (cmd.respond)
        begin
            rsp_reg.status    <= res_status_reg;
            rsp_reg.value_out <= memo_htqp_pkg::FIELD_BITS'(res_value_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // status to controller
    assign stat.clear_last = (slot_reg == SLOT_BITS'(memo_htqp_pkg::CAPACITY - 1));
    assign stat.probe_done = resolved || exhausted;
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

endmodule

// File: src/memo_hash_table_quadratic_probe.sv
// top level of the memo hash table with quadratic probing
//
//   channel   handshake             word
//   --------  --------------------  -----------------------------------------
//   req       req_valid/req_ready   cmd, rule_index, position, value_in
//   rsp       rsp_valid/rsp_ready   status, value_out
//   cfg       cfg_we                max_entries, written at once
//
// an operation probes at most MAX_PROBES slots, fewer when the home slot or
// a later one settles it; each probe is a ram read in S_ISSUE and then a
// compare in S_CHECK on the single slot ram
// after reset a sweep writes empty words to all CAPACITY slots, req_ready
// stays low during the sweep, cfg writes are taken as usual
// a new request is accepted while the previous result waits in the output
// register; a result finished before that one is taken waits for rsp_ready
module memo_hash_table_quadratic_probe (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  memo_htqp_pkg::req_t                req,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output memo_htqp_pkg::rsp_t                rsp,
    input  logic                               cfg_we,
    input  logic [memo_htqp_pkg::CFG_BITS-1:0] cfg_data
);

`include "memo_hash_table_quadratic_probe_assert.svh"

    memo_htqp_pkg::ctrl_cmd_t    cmd;
    memo_htqp_pkg::ctrl_status_t stat;

    // controller
    memo_htqp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    memo_htqp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    // no word taken or shown while the sweep runs
    `MHTQ_ASSERT_IMPLIES(a_clear_quiet, clk, rst_n, cmd.clear, !req_ready && !rsp_valid)
    // one operation at a time
    `MHTQ_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)
    // a finished result reaches the output
    `MHTQ_ASSERT_NEXT(a_respond_shows, clk, rst_n, cmd.respond, rsp_valid)
    // at most one command per cycle
    `MHTQ_ASSERT_IMPLIES(a_single_cmd, clk, rst_n, 1'b1, $onehot0(cmd))

endmodule
